// File: src/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: src/asdm_pkg.sv
// Package: widths, register indexes and reset values of the angle sensor map.
`timescale 1ns / 1ps

package asdm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_W    = 16;
  localparam int ANGLE_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // used bits of the converter word
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MARGIN = 3'd5;

  // reset values
  localparam logic [SAMPLE_W-1:0]       RST_VOLT_LOW   = 16'd0;
  localparam logic [SAMPLE_W-1:0]       RST_VOLT_HIGH  = 16'hFFFF;
  localparam logic signed [ANGLE_W-1:0] RST_ANGLE_LOW  = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] RST_ANGLE_HIGH = 16'sd9000;
  localparam logic [SAMPLE_W-1:0]       RST_NOISE_BAND = 16'd64;
  localparam logic [SAMPLE_W-1:0]       RST_SAT_MARGIN = 16'd0;

  // shift-add and restoring-divide step count, one bit per cycle
  localparam int STEPS = 16;
  localparam int CNT_W = $clog2(STEPS);

endpackage

// File: src/angle_sensor_deadband_map_top.sv
// Top level: angle sensor limit check, noise dead band and linear angle map.
`timescale 1ns / 1ps
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  input   | in_valid / in_ready     | adc_sample
//  output  | out_valid / out_ready   | angle_out, circuit_fault
//  config  | cfg_we (no wait)        | cfg_index, cfg_data
//
// A word that stays inside the dead band, or that saturates, goes from the
// check straight to the output load. A mapped word passes through the
// check, setup, 16 shift-add multiply steps and 16 restoring divide steps on
// the one shared 17-bit adder/subtractor, a final offset and the output load.
// in_ready is high only while the sequencer is idle; the output register
// lets the next word be accepted while a result still waits for out_ready.
// A stalled result holds in the output register; the sequencer waits in its
// last step until the register is free. Reset (synchronous, rst) restores
// the register defaults and clears the kept sample and held angle.

module angle_sensor_deadband_map_top import asdm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [SAMPLE_W-1:0]         adc_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [ANGLE_W-1:0]   angle_out,
  output logic                        circuit_fault,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration registers
  logic [SAMPLE_W-1:0]       volt_low;
  logic [SAMPLE_W-1:0]       volt_high;
  logic signed [ANGLE_W-1:0] angle_low;
  logic signed [ANGLE_W-1:0] angle_high;
  logic [SAMPLE_W-1:0]       noise_band;
  logic [SAMPLE_W-1:0]       sat_margin;

  // sequencer and datapath
  logic [2:0]                state;
  logic [CNT_W-1:0]          cnt;
  logic [SAMPLE_W-1:0]       code;
  logic [SAMPLE_W-1:0]       kept_sample;
  logic signed [ANGLE_W-1:0] held_angle;
  logic                      fault;
  logic [SAMPLE_W-1:0]       span;
  logic [ANGLE_W-1:0]        mag;
  logic                      neg;
  logic [2*SAMPLE_W-1:0]     p;     // product, then {remainder, quotient}

  // output register load
  logic                      load_out;

  // check-step values
  logic [SAMPLE_W-1:0] diff;
  logic                update;
  logic [SAMPLE_W:0]   low_lim;
  logic                low_sat;
  logic                high_sat;
  logic                no_span;
  logic                flt;

  // shared adder/subtractor
  logic [SAMPLE_W:0]   alu_a;
  logic [SAMPLE_W:0]   alu_b;
  logic                alu_sub;
  logic [SAMPLE_W+1:0] alu_y;

  // final offset
  logic signed [ANGLE_W+1:0] base;
  logic signed [ANGLE_W+1:0] quo;
  logic signed [ANGLE_W+1:0] res;
  logic signed [ANGLE_W-1:0] res_sat;

  // prep values
  logic signed [ANGLE_W:0]   d_ha;
  logic signed [ANGLE_W:0]   d_ah;
  logic                      ah_lt_al;

  assign in_ready = (state == S_IDLE);

  // result leaves the sequencer when the output register is empty or draining
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    diff     = (code > kept_sample) ? code - kept_sample : kept_sample - code;
    update   = diff > noise_band;
    low_lim  = {1'b0, volt_low} + {1'b0, sat_margin};
    low_sat  = {1'b0, code} <= low_lim;
    high_sat = code >= volt_high;
    no_span  = volt_high <= volt_low;
    flt      = (code < volt_low) || (code > volt_high);
  end

  always_comb begin
    d_ha     = {angle_high[ANGLE_W-1], angle_high} - {angle_low[ANGLE_W-1], angle_low};
    d_ah     = {angle_low[ANGLE_W-1], angle_low} - {angle_high[ANGLE_W-1], angle_high};
    ah_lt_al = angle_high < angle_low;
  end

  // Multiply: add magnitude when the low bit is set, shift right.
  // Divide: shift the remainder left, subtract the span, keep on no borrow.
  always_comb begin
    if (state == S_DIV) begin
      alu_a   = p[2*SAMPLE_W-1:SAMPLE_W-1];
      alu_b   = {1'b0, span};
      alu_sub = 1'b1;
    end else begin
      alu_a   = {1'b0, p[2*SAMPLE_W-1:SAMPLE_W]};
      alu_b   = p[0] ? {1'b0, mag} : '0;
      alu_sub = 1'b0;
    end
    alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // Quotient stays below the angle span, so the result lies between limits;
  // clamp anyway.
  always_comb begin
    base = {{2{angle_low[ANGLE_W-1]}}, angle_low};
    quo  = {2'b00, p[SAMPLE_W-1:0]};
    res  = neg ? base - quo : base + quo;
    if (res > 18'sd32767) begin
      res_sat = 16'sh7FFF;
    end else if (res < -18'sd32768) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = res[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_low   <= RST_VOLT_LOW;
      volt_high  <= RST_VOLT_HIGH;
      angle_low  <= RST_ANGLE_LOW;
      angle_high <= RST_ANGLE_HIGH;
      noise_band <= RST_NOISE_BAND;
      sat_margin <= RST_SAT_MARGIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOLT_LOW:   volt_low   <= cfg_data;
        REG_VOLT_HIGH:  volt_high  <= cfg_data;
        REG_ANGLE_LOW:  angle_low  <= cfg_data;
        REG_ANGLE_HIGH: angle_high <= cfg_data;
        REG_NOISE_BAND: noise_band <= cfg_data;
        REG_SAT_MARGIN: sat_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kept_sample <= '0;
      held_angle  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            code  <= adc_sample & SAMPLE_MASK;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          fault <= flt;
          if (update) begin
            kept_sample <= code;
            priority if (low_sat) begin
              held_angle <= angle_low;
              state      <= S_DONE;
            end else if (high_sat || no_span) begin
              held_angle <= angle_high;
              state      <= S_DONE;
            end else begin
              state <= S_PREP;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_PREP: begin
          span  <= volt_high - volt_low;
          mag   <= ah_lt_al ? d_ah[ANGLE_W-1:0] : d_ha[ANGLE_W-1:0];
          neg   <= ah_lt_al;
          p     <= {{SAMPLE_W{1'b0}}, code - volt_low};
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          p   <= {alu_y[SAMPLE_W:0], p[SAMPLE_W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // borrow set: restore, i.e. keep the shifted remainder
          p <= {(alu_y[SAMPLE_W+1] ? p[2*SAMPLE_W-2:SAMPLE_W-1] : alu_y[SAMPLE_W-1:0]),
                p[SAMPLE_W-2:0], ~alu_y[SAMPLE_W+1]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          held_angle <= res_sat;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            angle_out     <= held_angle;
            circuit_fault <= fault;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/asdm_checker.sv
// Port-level checker for the angle sensor map, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asdm_checker import asdm_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [SAMPLE_W-1:0]       adc_sample,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [ANGLE_W-1:0] angle_out,
  input logic                      circuit_fault
);

  // one word at a time: busy right after an accept
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)

  // a new result is loaded only from the busy sequencer
  `ASSERT_CLK(a_result_from_busy, clk, rst, $rose(out_valid) |-> !$past(in_ready))

  // nothing comes out in the first cycle after reset
  `ASSERT_CLK(a_empty_after_reset, clk, rst, $past(rst) |-> !out_valid)

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(angle_out) && $stable(circuit_fault)))

  // an accepted sample is never unknown
  `ASSERT_NEVER(a_accept_while_unknown, clk, rst, in_valid && in_ready && $isunknown(adc_sample))

endmodule

bind angle_sensor_deadband_map_top asdm_checker u_asdm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .adc_sample    (adc_sample),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .angle_out     (angle_out),
  .circuit_fault (circuit_fault)
);

// File: dv/angle_sensor_deadband_map_top_test.sv
// Testbench for the angle sensor limit check, dead band and linear angle map.
`timescale 1ns / 1ps

module angle_sensor_deadband_map_top_test;
  import asdm_pkg::*;

  // Spare register slots past the list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Cycles to let pass after the last result before the run closes.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      fault;
  } angle_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [SAMPLE_W-1:0]       adc_sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] angle_out;
  logic                      circuit_fault;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  angle_sensor_deadband_map_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .adc_sample    (adc_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .angle_out     (angle_out),
    .circuit_fault (circuit_fault),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file and the sensor state.
  logic [SAMPLE_W-1:0]       volt_lo  = RST_VOLT_LOW;
  logic [SAMPLE_W-1:0]       volt_hi  = RST_VOLT_HIGH;
  logic signed [ANGLE_W-1:0] ang_lo   = RST_ANGLE_LOW;
  logic signed [ANGLE_W-1:0] ang_hi   = RST_ANGLE_HIGH;
  logic [SAMPLE_W-1:0]       band     = RST_NOISE_BAND;
  logic [SAMPLE_W-1:0]       margin   = RST_SAT_MARGIN;
  logic [SAMPLE_W-1:0]       kept_code = '0;
  logic signed [ANGLE_W-1:0] held_ang  = '0;

  // Expected words in acceptance order.
  angle_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_errors      = 0;
  int n_words       = 0;
  int n_results     = 0;
  int n_updates     = 0;
  int n_faults      = 0;
  int n_cfg_writes  = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Linear map of one accepted code, quotient truncated toward zero.
  // Low saturation (low limit plus margin, no wrap) wins over high
  // saturation; an empty or inverted span falls to the high angle.
  function automatic logic signed [ANGLE_W-1:0] map_code(logic [SAMPLE_W-1:0] code);
    longint span, num, q;
    if (longint'(code) <= longint'(volt_lo) + longint'(margin)) return ang_lo;
    if (code >= volt_hi) return ang_hi;
    span = longint'(volt_hi) - longint'(volt_lo);
    if (span <= 0) return ang_hi;
    num = (longint'(code) - longint'(volt_lo)) * (longint'(ang_hi) - longint'(ang_lo));
    q = num / span + longint'(ang_lo);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return ANGLE_W'(q);
  endfunction

  // Fault flag for every word; state moves only outside the dead band.
  function automatic angle_result_t predict_angle(logic [SAMPLE_W-1:0] raw);
    angle_result_t res;
    logic [SAMPLE_W-1:0] code;
    logic [SAMPLE_W-1:0] diff;
    code = raw & SAMPLE_MASK;
    res.fault = (code < volt_lo) || (code > volt_hi);
    diff = (code > kept_code) ? code - kept_code : kept_code - code;
    if (diff > band) begin
      kept_code = code;
      held_ang  = map_code(code);
      n_updates++;
    end
    res.angle = held_ang;
    if (res.fault) n_faults++;
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_VOLT_LOW:   volt_lo = data;
      REG_VOLT_HIGH:  volt_hi = data;
      REG_ANGLE_LOW:  ang_lo  = data;
      REG_ANGLE_HIGH: ang_hi  = data;
      REG_NOISE_BAND: band    = data;
      REG_SAT_MARGIN: margin  = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Send one word; valid stays up across back-to-back words.
  task automatic send_word(input logic [SAMPLE_W-1:0] raw);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    adc_sample <= raw;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_angle(raw));
    n_words++;
  endtask

  // Hold off the sender until every expected word is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back writes keep cfg_we high; end_cfg drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    n_cfg_writes++;
  endtask

  task automatic end_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] vl, input logic [15:0] vh, input logic [15:0] al,
                           input logic [15:0] ah, input logic [15:0] nb, input logic [15:0] sm);
    wait_drained();
    write_reg(REG_VOLT_LOW, vl);
    write_reg(REG_VOLT_HIGH, vh);
    write_reg(REG_ANGLE_LOW, al);
    write_reg(REG_ANGLE_HIGH, ah);
    write_reg(REG_NOISE_BAND, nb);
    write_reg(REG_SAT_MARGIN, sm);
    end_cfg();
  endtask

  // Receiver: random back-pressure per cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    angle_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none, actual angle %0d fault %0b",
                 $time, angle_out, circuit_fault);
        n_errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (angle_out !== exp_res.angle) begin
          $display("%0t angle_out mismatch: expected %0d, actual %0d",
                   $time, exp_res.angle, angle_out);
          n_errors++;
        end
        if (circuit_fault !== exp_res.fault) begin
          $display("%0t circuit_fault mismatch: expected %0b, actual %0b",
                   $time, exp_res.fault, circuit_fault);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly codes around the kept sample and the limits, so the dead band
  // edges and both saturation rules are hit often; the rest is uniform or at the code extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r, val, b, sel;
    r = $urandom_range(0, 99);
    b = int'(band);
    if (r < 35) begin
      val = int'(kept_code) + int'($urandom_range(0, 2 * b + 4)) - (b + 2);
    end else if (r < 45) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: val = int'(kept_code) + b;
        1: val = int'(kept_code) - b;
        2: val = int'(kept_code) + b + 1;
        default: val = int'(kept_code) - b - 1;
      endcase
    end else if (r < 70) begin
      val = $urandom_range(0, 65535);
    end else if (r < 80) begin
      sel = $urandom_range(0, 2);
      case (sel)
        0: val = int'(volt_lo);
        1: val = int'(volt_lo) + int'(margin);
        default: val = int'(volt_hi);
      endcase
      val = val + int'($urandom_range(0, 4)) - 2;
    end else if (r < 90) begin
      val = $urandom_range(0, 1) ? 65535 : 0;
    end else if (volt_hi > volt_lo) begin
      val = $urandom_range(int'(volt_lo), int'(volt_hi));
    end else begin
      val = $urandom_range(0, 65535);
    end
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return val[SAMPLE_W-1:0];
  endfunction

  task automatic randomize_regs();
    logic [15:0] vl, vh, al, ah, nb, sm;
    int r;
    r  = $urandom_range(0, 99);
    al = 16'($urandom);
    ah = 16'($urandom);
    if (r < 10) begin
      // full code range onto the full angle range, either direction
      vl = 16'h0000;
      vh = 16'hFFFF;
      al = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      ah = ~al;
    end else if (r < 75) begin
      vl = 16'($urandom_range(0, 20000));
      vh = 16'($urandom_range(40000, 65535));
    end else if (r < 88) begin
      vl = 16'($urandom);
      vh = 16'($urandom);
    end else begin
      vl = 16'($urandom);
      vh = vl;
    end
    r = $urandom_range(0, 99);
    if (r < 60)      nb = 16'($urandom_range(0, 300));
    else if (r < 75) nb = 16'h0000;
    else if (r < 85) nb = 16'hFFFF;
    else             nb = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55)      sm = 16'($urandom_range(0, 3000));
    else if (r < 80) sm = 16'h0000;
    else if (r < 90) sm = 16'hFFFF;
    else             sm = 16'($urandom);
    write_all(vl, vh, al, ah, nb, sm);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset values: band edge at 64, first mapped word, both saturations.
  task automatic test_reset_defaults();
    send_word(16'd64);
    send_word(16'd65);
    send_word(16'hFFFF);
    send_word(16'd0);
  endtask

  // Fault flag on both sides of the valid window, full angle range.
  task automatic test_fault_limits();
    write_all(16'd1000, 16'd60000, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
    send_word(16'd999);
    send_word(16'd1000);
    send_word(16'd1001);
    send_word(16'd60000);
    send_word(16'd60001);
    send_word(16'd0);
    send_word(16'hFFFF);
  endtask

  // Change equal to the band is held; one more code moves the angle.
  task automatic test_dead_band();
    write_all(16'd0, 16'hFFFF, -16'sd9000, 16'sd9000, 16'd100, 16'd0);
    send_word(16'd65435);
    send_word(16'd65434);
    send_word(16'd65334);
    send_word(16'd65333);
  endtask

  // Margin wide enough that low saturation beats the high limit.
  task automatic test_saturation_margin();
    write_all(16'd40000, 16'd50000, 16'sd1234, -16'sd4321, 16'd0, 16'hFFFF);
    send_word(16'd12345);
    send_word(16'd50000);
    send_word(16'hFFFF);
  endtask

  // Zero span, then an inverted window.
  task automatic test_zero_span();
    write_all(16'd30000, 16'd30000, -16'sd500, 16'sd500, 16'd0, 16'd0);
    send_word(16'd29999);
    send_word(16'd30001);
    write_all(16'd50000, 16'd10000, -16'sd500, 16'sd500, 16'd0, 16'd0);
    send_word(16'd30000);
    send_word(16'd5000);
  endtask

  // Writes past the register list change nothing.
  task automatic test_spare_index();
    wait_drained();
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    end_cfg();
    send_word(16'd20000);
  endtask

  // Random epochs: new settings, then a burst of words with a drain pause halfway and at random.
  task automatic test_random_traffic(input int n_total, input int s_idle, input int r_idle);
    int remaining, n;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    remaining = n_total;
    while (remaining > 0) begin
      randomize_regs();
      n = $urandom_range(40, 160);
      if (n > remaining) n = remaining;
      for (int i = 0; i < n; i++) begin
        send_word(pick_sample());
        if (i == n / 2 || $urandom_range(0, 99) == 0) wait_drained();
      end
      remaining -= n;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int spins;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 53;
    test_reset_defaults();
    test_fault_limits();
    test_dead_band();
    test_saturation_margin();
    test_zero_span();
    test_spare_index();

    test_random_traffic(480, 18, 53);
    test_random_traffic(480, 53, 18);
    test_random_traffic(465, 0, 0);

    // drain, then give the block time to show any stray word
    in_valid <= 1'b0;
    recv_idle_pct = 0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (pending_results.size() != 0 && spins < DRAIN_LIMIT);
    if (pending_results.size() != 0) begin
      $display("%0t missing words: expected %0d more, actual 0",
               $time, pending_results.size());
      n_errors += pending_results.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d angle updates, %0d fault flags, %0d register writes.",
             n_words, n_updates, n_faults, n_cfg_writes);
    $display("Checked %0d output words under three idle mixes; %0d errors.",
             n_results, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: fails and ends the run if the main sequence has not finished.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
